// ----- rtl/core/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes and fixed port widths shared by the fixed-point ALU files.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int OPCODE_W = 4;
   localparam int DATA_W   = 32;
   localparam int WHOLE_W  = 24;

   typedef logic [OPCODE_W-1:0] opcode_type;

   localparam opcode_type OP_ADD     = 4'd0;
   localparam opcode_type OP_SUB     = 4'd1;
   localparam opcode_type OP_MUL     = 4'd2;
   localparam opcode_type OP_DIV     = 4'd3;
   localparam opcode_type OP_CMP     = 4'd4;
   localparam opcode_type OP_MIN     = 4'd5;
   localparam opcode_type OP_MAX     = 4'd6;
   localparam opcode_type OP_INC     = 4'd7;
   localparam opcode_type OP_DEC     = 4'd8;
   localparam opcode_type OP_FROM_INT = 4'd9;
   localparam opcode_type OP_TO_INT  = 4'd10;

endpackage

// ----- rtl/core/fpa_ifs.sv -----
// ----------------------------------------------------------------------------
// fpa_ifs
// Request and response channels of the fixed-point ALU.
// ----------------------------------------------------------------------------
interface fpa_req_if;
   import fpa_pkg::*;
   logic                      valid;
   logic                      ready;
   opcode_type                opcode;
   logic signed [DATA_W-1:0]  operand_a;
   logic signed [DATA_W-1:0]  operand_b;
   logic signed [WHOLE_W-1:0] whole_value;
   modport source (output valid, opcode, operand_a, operand_b, whole_value, input ready);
   modport sink   (input valid, opcode, operand_a, operand_b, whole_value, output ready);
endinterface

interface fpa_rsp_if;
   import fpa_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result;
   logic                     a_less;
   logic                     a_equal;
   logic                     a_greater;
   logic                     overflow;
   logic                     divide_by_zero;
   modport source (output valid, result, a_less, a_equal, a_greater, overflow,
                   divide_by_zero, input ready);
   modport sink   (input valid, result, a_less, a_equal, a_greater, overflow,
                   divide_by_zero, output ready);
endinterface

// ----- rtl/core/fixed_point_alu_q24_8.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, compare, min, max, inc,
// dec and integer conversions, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// One operation enters per cycle unless the response stalls and leaves in
// order after one decode stage, one multiply/dividend setup stage, a chain of
// divider stages that each resolve four quotient bits of the exact rounded
// division, and an output stage that applies sign and saturation. Every
// opcode travels the full pipeline, so results come back in request order.
// Each stage holds its own valid bit and advances whenever the stage ahead
// is empty or moving, so a stalled response backs up the pipe one stage at
// a time and bubbles are squeezed out; the request side stays ready until
// every stage holds a transfer and the response is stalled. Multiply and
// divide round half away from zero; out-of-range results clamp to the signed
// word limits and raise overflow; divide by zero returns 0 with its own flag.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
   parameter int FRACTION_BITS = 8,
   parameter int WORD_WIDTH    = 32
) (
   input  logic         clock,
   input  logic         reset,
   fpa_req_if.sink      req_if,
   fpa_rsp_if.source    rsp_if
);
   import fpa_pkg::*;

   localparam int W   = WORD_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int QB  = W + 1;
   localparam int NW  = W + F + 2;
   localparam int SPS = 4;
   localparam int DIV_STAGES = (QB + SPS - 1) / SPS;
   localparam int S   = DIV_STAGES + 3;
   localparam int PW  = 2 * W;
   localparam int FW  = WHOLE_W + F;
   localparam int XW  = ((FW > W) ? FW : W) + 1;

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      opcode_type          op;
      logic                lt;
      logic                eq;
      logic                gt;
      logic                neg;
      logic                dz;
      logic                ovf;
      logic                big;
      logic [W-1:0]        res;
      logic [W-1:0]        ma;
      logic [W-1:0]        mb;
      logic [PW-1:0]       prod;
      logic [W:0]          rem;
      logic [QB-1:0]       low;
      logic [QB-1:0]       quo;
      logic [W:0]          den;
   } pipe_type;

   pipe_type      pipe_ff [S];
   pipe_type      pipe_in [S];
   logic [S-1:0]  valid_ff;
   logic [S-1:0]  adv;

   // advance a stage when it is empty or its successor advances
   always_comb begin
      adv[S-1] = !valid_ff[S-1] || rsp_if.ready;
      for (int k = S - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_if.ready = adv[0];

   // decode stage: compare flags, simple ops, magnitudes
   always_comb begin
      logic signed [W-1:0]  a;
      logic signed [W-1:0]  b;
      logic signed [W:0]    wide;
      logic signed [XW-1:0] conv;
      pipe_type             p;
      a    = req_if.operand_a[W-1:0];
      b    = req_if.operand_b[W-1:0];
      p    = '0;
      p.op = req_if.opcode;
      p.lt = (a < b);
      p.eq = (a == b);
      p.gt = (a > b);
      p.neg = a[W-1] ^ b[W-1];
      p.ma = a[W-1] ? W'(-a) : W'(a);
      p.mb = b[W-1] ? W'(-b) : W'(b);
      wide = '0;
      conv = XW'(signed'({req_if.whole_value, {F{1'b0}}}));
      case (req_if.opcode)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            if (req_if.opcode == OP_ADD) begin
               wide = {a[W-1], a} + {b[W-1], b};
            end else if (req_if.opcode == OP_SUB) begin
               wide = {a[W-1], a} - {b[W-1], b};
            end else if (req_if.opcode == OP_INC) begin
               wide = {a[W-1], a} + (W+1)'(1);
            end else begin
               wide = {a[W-1], a} - (W+1)'(1);
            end
            p.ovf = wide[W] ^ wide[W-1];
            p.res = p.ovf ? (wide[W] ? WMIN : WMAX) : wide[W-1:0];
         end
         OP_MIN:      p.res = (b < a) ? b : a;
         OP_MAX:      p.res = (b > a) ? b : a;
         OP_TO_INT:   p.res = a >>> F;
         OP_FROM_INT: begin
            if (conv > XW'(WMAX)) begin
               p.ovf = 1'b1;
               p.res = WMAX;
            end else if (conv < XW'(WMIN)) begin
               p.ovf = 1'b1;
               p.res = WMIN;
            end else begin
               p.res = conv[W-1:0];
            end
         end
         OP_DIV:      p.dz = (b == '0);
         default:     p.res = '0;
      endcase
      pipe_in[0] = p;
   end

   // setup stage: magnitude product, dividend and divisor for rounding division
   always_comb begin
      logic [NW-1:0] num;
      pipe_type      p;
      p      = pipe_ff[0];
      num    = {p.ma, {F{1'b0}}, 1'b0} + NW'(p.mb);
      p.prod = PW'(p.ma) * PW'(p.mb);
      p.den  = {p.mb, 1'b0};
      p.big  = ((W+1)'(num[NW-1:QB]) >= p.den);
      p.rem  = (W+1)'(num[NW-1:QB]);
      p.low  = num[QB-1:0];
      p.quo  = '0;
      pipe_in[1] = p;
   end

   // divider stages; the first also rounds the product
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [W:0]    rem_n;
      logic [QB-1:0] low_n;
      logic [QB-1:0] quo_n;

      fpa_div_step #(
         .REM_W (W + 1),
         .QB    (QB),
         .STEPS (SPS),
         .FIRST (s * SPS)
      ) u_step (
         .rem_i (pipe_ff[s+1].rem),
         .low_i (pipe_ff[s+1].low),
         .quo_i (pipe_ff[s+1].quo),
         .den_i (pipe_ff[s+1].den),
         .rem_o (rem_n),
         .low_o (low_n),
         .quo_o (quo_n)
      );

      always_comb begin
         pipe_type p;
         p     = pipe_ff[s+1];
         p.rem = rem_n;
         p.low = low_n;
         p.quo = quo_n;
         if (s == 0) begin
            p.prod = (p.prod + PW'(1 << (F - 1))) >> F;
         end
         pipe_in[s+2] = p;
      end
   end

   // output stage: apply sign and saturate mul/div magnitudes
   always_comb begin
      logic [PW-1:0] mag;
      logic [PW-1:0] lim;
      logic          sat;
      pipe_type      p;
      p   = pipe_ff[S-2];
      mag = (p.op == OP_MUL) ? p.prod : PW'(p.quo);
      lim = p.neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
      sat = (mag > lim) || ((p.op == OP_DIV) && p.big);
      if ((p.op == OP_MUL) || ((p.op == OP_DIV) && !p.dz)) begin
         p.ovf = sat;
         if (sat) begin
            p.res = p.neg ? WMIN : WMAX;
         end else begin
            p.res = p.neg ? W'(-mag[W-1:0]) : mag[W-1:0];
         end
      end else if (p.op == OP_DIV) begin
         p.ovf = 1'b0;
         p.res = '0;
      end
      pipe_in[S-1] = p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_if.valid;
         end
         for (int k = 1; k < S; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // payload holds while its stage stalls
   always_ff @(posedge clock) begin
      for (int k = 0; k < S; k++) begin
         if (adv[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_if.valid          = valid_ff[S-1];
   assign rsp_if.result         = DATA_W'(signed'(pipe_ff[S-1].res));
   assign rsp_if.a_less         = pipe_ff[S-1].lt;
   assign rsp_if.a_equal        = pipe_ff[S-1].eq;
   assign rsp_if.a_greater      = pipe_ff[S-1].gt;
   assign rsp_if.overflow       = pipe_ff[S-1].ovf;
   assign rsp_if.divide_by_zero = pipe_ff[S-1].dz;

   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> $onehot({rsp_if.a_less, rsp_if.a_equal, rsp_if.a_greater}))
      else $error("compare flags not one-hot");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.divide_by_zero) |-> (rsp_if.result == '0 && !rsp_if.overflow))
      else $error("divide by zero with nonzero result or overflow");

   a_take_in: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> valid_ff[0])
      else $error("accepted request lost at decode stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[S-1] && !rsp_if.ready) |=> (valid_ff[S-1] && $stable(pipe_ff[S-1].res)))
      else $error("stalled response changed");

endmodule

// ----- rtl/core/fpa_div_step.sv -----
// ----------------------------------------------------------------------------
// fpa_div_step
// STEPS restoring division steps: shift in one dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module fpa_div_step #(
   parameter int REM_W   = 33,
   parameter int QB      = 33,
   parameter int STEPS   = 4,
   parameter int FIRST   = 0
) (
   input  logic [REM_W-1:0] rem_i,
   input  logic [QB-1:0]    low_i,
   input  logic [QB-1:0]    quo_i,
   input  logic [REM_W-1:0] den_i,
   output logic [REM_W-1:0] rem_o,
   output logic [QB-1:0]    low_o,
   output logic [QB-1:0]    quo_o
);

   always_comb begin
      logic [REM_W:0]   t;
      logic [REM_W-1:0] r;
      logic [QB-1:0]    l;
      logic [QB-1:0]    q;
      logic             ge;
      r = rem_i;
      l = low_i;
      q = quo_i;
      for (int j = 0; j < STEPS; j++) begin
         if (FIRST + j < QB) begin
            t  = {r, l[QB-1]};
            ge = (t >= {1'b0, den_i});
            if (ge) begin
               t = t - {1'b0, den_i};
            end
            r = t[REM_W-1:0];
            q = {q[QB-2:0], ge};
            l = {l[QB-2:0], 1'b0};
         end
      end
      rem_o = r;
      low_o = l;
      quo_o = q;
   end

endmodule
